// File: design/xiod_pkg.sv
// shared types and constants for the x86 i/o instruction decoder
`default_nettype none

package xiod_pkg;

    // longest instruction accepted, in bytes
    localparam int MAX_LENGTH = 15;

    // decode phases
    localparam logic [1:0] PH_PREFIX = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_IMM    = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNSUP = 2'd1;
    localparam logic [1:0] ST_LONG  = 2'd2;

    // prefix and opcode bytes
    localparam logic [7:0] PFX_ES      = 8'h26;
    localparam logic [7:0] PFX_CS      = 8'h2E;
    localparam logic [7:0] PFX_SS      = 8'h36;
    localparam logic [7:0] PFX_DS      = 8'h3E;
    localparam logic [7:0] PFX_FS      = 8'h64;
    localparam logic [7:0] PFX_GS      = 8'h65;
    localparam logic [7:0] PFX_LOCK    = 8'hF0;
    localparam logic [7:0] PFX_OPSIZE  = 8'h66;
    localparam logic [7:0] PFX_ADSIZE  = 8'h67;
    localparam logic [7:0] PFX_REPNE   = 8'hF2;
    localparam logic [7:0] PFX_REP     = 8'hF3;
    localparam logic [7:0] OP_TWO_BYTE = 8'h0F;
    localparam logic [7:0] OP_IN_IB    = 8'hE4;
    localparam logic [7:0] OP_IN_IV    = 8'hE5;
    localparam logic [7:0] OP_OUT_IB   = 8'hE6;
    localparam logic [7:0] OP_OUT_IV   = 8'hE7;
    localparam logic [7:0] OP_IN_DB    = 8'hEC;
    localparam logic [7:0] OP_IN_DV    = 8'hED;
    localparam logic [7:0] OP_OUT_DB   = 8'hEE;
    localparam logic [7:0] OP_OUT_DV   = 8'hEF;
    localparam logic [3:0] REX_HIGH    = 4'h4;
    localparam int         REX_W_BIT   = 3;

    // per-instruction decode state
    typedef struct packed {
        logic [1:0] phase;
        logic       rex_seen;
        logic       data16;
        logic       addr32;
        logic       rep;
        logic [3:0] count;
        logic [1:0] op_lo;
    } dec_state_t;

    localparam dec_state_t DEC_CLEAR = '{
        phase: PH_PREFIX, rex_seen: 1'b0, data16: 1'b0, addr32: 1'b0,
        rep: 1'b0, count: 4'd0, op_lo: 2'd0};

    // result of one decode step
    typedef struct packed {
        logic        valid;
        logic [31:0] exit_info;
        logic [3:0]  len;
        logic [1:0]  status;
    } dec_result_t;

endpackage

`default_nettype wire

// File: design/xiod_decode.sv
// combinational decode of one instruction byte against the current state
`default_nettype none

module xiod_decode (
    input  wire xiod_pkg::dec_state_t  state,
    input  wire logic [7:0]            instr_byte,
    input  wire logic                  first_byte,
    input  wire logic [15:0]           dx_port,
    output xiod_pkg::dec_state_t       state_next,
    output xiod_pkg::dec_result_t      result
);
    import xiod_pkg::*;

    dec_state_t  cur;
    logic [4:0]  n;

    // pack the i/o exit-info word
    function automatic logic [31:0] io_word(input logic [1:0] op, input logic data16,
                                            input logic addr32, input logic rep,
                                            input logic [15:0] port);
        logic [31:0] w;
        w = '0;
        w[0] = ~op[1];
        if (!op[0])
        begin
            w[4] = 1'b1;
        end
        else if (data16)
        begin
            w[5] = 1'b1;
        end
        else
        begin
            w[6] = 1'b1;
        end
        if (addr32)
        begin
            w[8] = 1'b1;
        end
        else
        begin
            w[9] = 1'b1;
        end
        w[3] = rep;
        w[31:16] = port;
        return w;
    endfunction

    assign cur = first_byte ? DEC_CLEAR : state;
    assign n   = {1'b0, cur.count} + 5'd1;

    // one step of the prefix / opcode decoder
    always_comb
    begin
        state_next = cur;
        result     = '0;
        if (cur.phase != PH_DONE)
        begin
            if (n > 5'(MAX_LENGTH))
            begin
                result           = '{valid: 1'b1, exit_info: 32'd0,
                                     len: 4'(MAX_LENGTH), status: ST_LONG};
                state_next.phase = PH_DONE;
            end
            else
            begin
                state_next.count = n[3:0];
                case (cur.phase)
                    PH_SECOND:
                    begin
                        result           = '{valid: 1'b1, exit_info: 32'd0,
                                             len: n[3:0], status: ST_UNSUP};
                        state_next.phase = PH_DONE;
                    end
                    PH_IMM:
                    begin
                        result = '{valid: 1'b1,
                                   exit_info: io_word(cur.op_lo, cur.data16, cur.addr32,
                                                      cur.rep, {8'h00, instr_byte}),
                                   len: n[3:0], status: ST_OK};
                        state_next.phase = PH_DONE;
                    end
                    default:
                    begin
                        if (instr_byte[7:4] == REX_HIGH)
                        begin
                            state_next.rex_seen = 1'b1;
                            if (instr_byte[REX_W_BIT])
                            begin
                                state_next.data16 = 1'b0;
                            end
                        end
                        else
                        begin
                            case (instr_byte)
                                PFX_ES, PFX_CS, PFX_SS, PFX_DS, PFX_FS, PFX_GS, PFX_LOCK:
                                begin
                                end
                                PFX_OPSIZE:
                                begin
                                    if (!cur.rex_seen)
                                    begin
                                        state_next.data16 = 1'b1;
                                    end
                                end
                                PFX_ADSIZE:
                                begin
                                    state_next.addr32 = 1'b1;
                                end
                                PFX_REPNE, PFX_REP:
                                begin
                                    state_next.rep = 1'b1;
                                end
                                OP_TWO_BYTE:
                                begin
                                    state_next.phase = PH_SECOND;
                                end
                                OP_IN_IB, OP_IN_IV, OP_OUT_IB, OP_OUT_IV:
                                begin
                                    state_next.op_lo = instr_byte[1:0];
                                    state_next.phase = PH_IMM;
                                end
                                OP_IN_DB, OP_IN_DV, OP_OUT_DB, OP_OUT_DV:
                                begin
                                    result = '{valid: 1'b1,
                                               exit_info: io_word(instr_byte[1:0],
                                                                  cur.data16, cur.addr32,
                                                                  cur.rep, dx_port),
                                               len: n[3:0], status: ST_OK};
                                    state_next.op_lo = instr_byte[1:0];
                                    state_next.phase = PH_DONE;
                                end
                                default:
                                begin
                                    result           = '{valid: 1'b1, exit_info: 32'd0,
                                                         len: n[3:0], status: ST_UNSUP};
                                    state_next.op_lo = instr_byte[1:0];
                                    state_next.phase = PH_DONE;
                                end
                            endcase
                        end
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// File: design/x86_io_instruction_decoder_top.sv
// x86 64-bit-mode prefix and i/o instruction decoder, top level
//
// Input channel (in_valid / in_ready): one instruction byte per word, with
// first_byte marking the start of an instruction and dx_port carrying DX.
// Output channel (out_valid / out_ready): one word per finished instruction:
// exit_info, instr_length and status (decoded, unsupported or too long).
// Prefix bytes, the 0F escape byte and the opcode byte of an immediate form give no output word;
// bytes after a finished instruction are dropped until the next first_byte.
// A word is captured in the input register at acceptance; the decode runs
// in the following cycle and its result is registered in the result
// register when that register is free or draining. One byte is taken
// every cycle while the output side keeps up; the rate is set by the single
// decode step between the input and result registers.
// Reset empties both registers and returns the decoder to the prefix phase;
// the first byte after reset starts an instruction even without first_byte.
// When the receiver stalls, the result register holds its word; the input
// register takes one more byte only if it is empty, and in_ready stays low
// while both registers are full and the stall lasts.
`default_nettype none

module x86_io_instruction_decoder_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  instr_byte,
    input  wire logic        first_byte,
    input  wire logic [15:0] dx_port,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      exit_info,
    output logic [3:0]       instr_length,
    output logic [1:0]       status
);
    import xiod_pkg::*;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        s1_first_reg;
    logic [15:0] s1_dx_reg;
    dec_state_t  state_reg;
    dec_state_t  state_next;
    dec_result_t res;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] exit_info_reg;
    logic [3:0]  len_reg;
    logic [1:0]  status_reg;
    logic        advance;

    // stage one moves on when the result register is free or draining
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;

    // input register
    assign s1_valid_next = in_ready ? in_valid : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg  <= instr_byte;
            s1_first_reg <= first_byte;
            s1_dx_reg    <= dx_port;
        end
    end

    // decode step
    xiod_decode u_decode (
        .state      (state_reg),
        .instr_byte (s1_byte_reg),
        .first_byte (s1_first_reg),
        .dx_port    (s1_dx_reg),
        .state_next (state_next),
        .result     (res)
    );

    // decode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DEC_CLEAR;
        end
        else if (s1_valid_reg && advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    assign out_valid_next = advance ? (s1_valid_reg && res.valid) : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg && res.valid)
        begin
            exit_info_reg <= res.exit_info;
            len_reg       <= res.len;
            status_reg    <= res.status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign exit_info    = exit_info_reg;
    assign instr_length = len_reg;
    assign status       = status_reg;

    // checks on decoder results and flow control
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_UNSUP || status == ST_LONG))
        else $error("status code out of range");

    a_fail_zero_info: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (exit_info == 32'd0))
        else $error("exit info not zero on failed decode");

    a_ok_sizes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OK) |-> ($onehot(exit_info[6:4]) && $onehot(exit_info[9:7])))
        else $error("data or address size not one-hot");

    a_ok_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (instr_length != 4'd0))
        else $error("zero instruction length");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input taken while both stages are full");

endmodule

`default_nettype wire
